[sv/mtbd_pkg.sv]
// Package for the MT19937 bounded draw block.
// Holds generator constants, tempering function and the front/back queue entry type.
package mtbd_pkg;

  localparam int unsigned TableWords  = 624;
  localparam int unsigned TwistOffset = 397;
  localparam int unsigned IdxW        = 10;

  localparam logic [31:0] SeedReset   = 32'd4357;
  localparam logic [31:0] SeedMult    = 32'd69069;
  localparam logic [31:0] TwistMatrix = 32'h9908b0df;
  localparam logic [31:0] TemperB     = 32'h9d2c5680;
  localparam logic [31:0] TemperC     = 32'hefc60000;

  // One queue entry: the bound and whether it draws at all.
  typedef struct packed {
    logic        draw;
    logic [31:0] bound;
  } job_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

[sv/mtbd_front.sv]
// Front end: accepts bound items, marks zero bounds, and queues them.
// Depends on mtbd_pkg.
module mtbd_front import mtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] bound,
  output logic        q_valid,
  input  logic        q_take,
  output job_t        q_job
);

  job_t       ent [2];
  logic [1:0] cnt;
  logic       rd, wr;

  assign in_stall = (cnt == 2'd2);
  assign wr       = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign rd       = q_valid && q_take;
  assign q_job    = ent[0];

  always_ff @(posedge clk) begin
    if (wr && (cnt == 2'd0 || (cnt == 2'd1 && rd))) begin
      ent[0] <= '{draw: (bound != 32'd0), bound: bound};
    end else if (rd) begin
      ent[0] <= ent[1];
    end
    if (wr && cnt == 2'd1 && !rd) begin
      ent[1] <= '{draw: (bound != 32'd0), bound: bound};
    end
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[sv/mtbd_back.sv]
// Back end: owns the twister table, seeds, twists the whole table when due, tempers,
// and reduces modulo the bound with a restoring divider. Depends on mtbd_pkg.
module mtbd_back import mtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  input  logic        q_valid,
  output logic        q_take,
  input  job_t        q_job,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [31:0] seed_readback
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FILL  = 9'b000000010,
    S_TW0   = 9'b000000100,
    S_TW1   = 9'b000001000,
    S_TW2   = 9'b000010000,
    S_RD    = 9'b000100000,
    S_TEMP  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [31:0] mem [TableWords];
  logic [31:0] rdata;
  logic [IdxW-1:0] raddr;
  logic        we;
  logic [IdxW-1:0] waddr;
  logic [31:0] wdata;

  logic [31:0] seed;
  logic        seeded;
  logic [IdxW-1:0] pos;     // next word; TableWords means a twist is due
  logic [IdxW-1:0] k;
  logic [31:0] prev, w_k, w_n;
  logic [31:0] bnd, quo, rem;
  logic [5:0]  bitc;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  function automatic logic [IdxW-1:0] wrap(input logic [IdxW:0] a);
    return (a >= (IdxW+1)'(TableWords)) ? IdxW'(a - (IdxW+1)'(TableWords)) : a[IdxW-1:0];
  endfunction

  logic [31:0] y, twv;
  logic [32:0] trial;
  assign y     = {w_k[31], w_n[30:0]};
  assign twv   = rdata ^ (y >> 1) ^ (y[0] ? TwistMatrix : 32'd0);
  assign trial = {rem[31:0], quo[31]} - {1'b0, bnd};

  // Twist of word k reads k+1 and k+397 (wrapped); word k was latched as w_k.
  // While a twist is due the read port follows k instead of the draw position.
  always_comb begin
    raddr = (pos == IdxW'(TableWords)) ? k : pos;
    we    = 1'b0;
    waddr = k;
    wdata = twv;
    case (state)
      S_FILL: begin
        we    = 1'b1;
        wdata = prev;
      end
      S_TW0:  raddr = wrap({1'b0, k} + 11'd1);
      S_TW1:  raddr = wrap({1'b0, k} + (IdxW+1)'(TwistOffset));
      S_TW2:  we = 1'b1;
      default: raddr = (pos == IdxW'(TableWords)) ? k : pos;
    endcase
  end

  assign q_take        = (state == S_OUT) && !out_stall;
  assign out_valid     = (state == S_OUT);
  assign seed_readback = seed;

  always_ff @(posedge clk) begin
    if (seed_we) begin
      seed   <= seed_wdata;
      seeded <= 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          bnd <= q_job.bound;
          if (!q_job.draw) begin
            rem   <= 32'd0;
            state <= S_OUT;
          end else if (!seeded) begin
            k     <= '0;
            prev  <= seed;
            state <= S_FILL;
          end else if (pos == IdxW'(TableWords)) begin
            k     <= '0;
            state <= S_RD;
          end else begin
            state <= S_RD;
          end
        end
      end
      S_FILL: begin
        prev <= prev * SeedMult;
        if (k == IdxW'(TableWords - 1)) begin
          // A freshly seeded table is always twisted before its first draw.
          seeded <= 1'b1;
          k      <= '0;
          state  <= S_RD;
          pos    <= IdxW'(TableWords);
        end else begin
          k <= k + 1'b1;
        end
      end
      S_TW0: state <= S_TW1;
      S_TW1: begin
        w_n   <= rdata;
        state <= S_TW2;
      end
      S_TW2: begin
        if (k == IdxW'(TableWords - 1)) begin
          pos   <= '0;
          state <= S_RD;
        end else begin
          k     <= k + 1'b1;
          state <= S_RD;
          pos   <= IdxW'(TableWords);
        end
      end
      S_RD: begin
        if (pos == IdxW'(TableWords)) begin
          // Continue the twist: fetch word k itself first.
          state <= S_TEMP;
        end else begin
          state <= S_TEMP;
        end
      end
      S_TEMP: begin
        if (pos == IdxW'(TableWords)) begin
          w_k   <= rdata;
          state <= S_TW0;
        end else begin
          quo   <= temper(rdata);
          rem   <= 32'd0;
          bitc  <= 6'd0;
          pos   <= pos + 1'b1;
          state <= S_DIV;
        end
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem <= trial[31:0];
        end else begin
          rem <= {rem[30:0], quo[31]};
        end
        quo  <= {quo[30:0], 1'b0};
        bitc <= bitc + 1'b1;
        if (bitc == 6'd31) begin
          state <= S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state <= S_IDLE;
        end
      end
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state  <= S_IDLE;
      seeded <= 1'b0;
      seed   <= SeedReset;
      pos    <= IdxW'(TableWords);
    end
  end

  assign value = rem;

endmodule

[sv/mersenne_twister_bounded_draw.sv]
// MT19937 bounded draw: each bound item yields one value, the next tempered
// word modulo the bound (0 for a zero bound, without advancing), plus the seed.
// A draw runs through S_RD, S_TEMP, the one-bit-per-cycle remainder unit and S_OUT,
// where out_stall can hold it. The first draw after reset or a seed write first
// seeds the 624-word table and then twists it, and it twists again once all 624
// words have been drawn; a twist steps each word through S_RD, S_TEMP, S_TW0,
// S_TW1 and S_TW2 over the one read port. Depends on mtbd_pkg.
module mersenne_twister_bounded_draw import mtbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value,
  output logic [31:0] seed_readback
);

  logic q_valid, q_take;
  job_t q_job;

  mtbd_front u_front (
    .clk, .rst, .in_valid, .in_stall, .bound,
    .q_valid, .q_take, .q_job
  );

  mtbd_back u_back (
    .clk, .rst, .seed_we(cfg_we), .seed_wdata(cfg_wdata),
    .q_valid, .q_take, .q_job,
    .out_valid, .out_stall, .value, .seed_readback
  );

endmodule
